// ===== design/svn_pkg.sv =====
package svn_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 13;
	localparam int POS_W        = 24;
	localparam int CORNER_W     = 32;
	localparam int ACC_W        = 64;
	localparam int DIFF_W       = POS_W + 1;
	localparam int FACE_W       = 2 * DIFF_W + 1;
	localparam int OUT_W        = 16;
	localparam int QUEUE_DEPTH  = 2;

	// item kinds on the input channel
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_TRI   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	// classified operations in the queue
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_TRI   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_QOOR  = 2'd3;

	typedef struct packed {
		logic [1:0]              op;
		logic [VIDX_W-1:0]       idx_a;
		logic [VIDX_W-1:0]       idx_b;
		logic [VIDX_W-1:0]       idx_c;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// ===== design/svn_item_if.sv =====
interface svn_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] vertex_index;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic [31:0] corner_a;
	logic [31:0] corner_b;
	logic [31:0] corner_c;

	modport source (output valid, kind, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, kind, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

// ===== design/svn_result_if.sv =====
interface svn_result_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic        used_fallback;
	logic        index_out_of_range;

	modport source (output valid, normal_x, normal_y, normal_z, used_fallback,
		index_out_of_range, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, used_fallback,
		index_out_of_range, output ready);
endinterface

// ===== design/svn_ram.sv =====
module svn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/svn_front.sv =====
module svn_front import svn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	svn_item_if.sink         items,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	input  back_status_t     status,
	input  logic             q_full,
	output logic             q_push,
	output cmd_t             q_cmd
);
	localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_VERTICES);

	logic [CNT_W-1:0]    vertex_count_q;
	logic [CNT_W-1:0]    eff_count;
	logic [CORNER_W-1:0] eff_wide;
	logic                tri_ok;
	logic                keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	assign eff_count = (vertex_count_q > MAXV) ? MAXV : vertex_count_q;
	assign eff_wide  = CORNER_W'(eff_count);
	assign tri_ok    = (items.corner_a < eff_wide) && (items.corner_b < eff_wide)
		&& (items.corner_c < eff_wide);

	assign items.ready = !q_full && !status.clearing;

	// classify: drop bad triangles and unknown kinds here
	always_comb begin
		q_cmd.idx_a = VIDX_W'(items.vertex_index);
		q_cmd.idx_b = '0;
		q_cmd.idx_c = '0;
		q_cmd.px    = items.pos_x;
		q_cmd.py    = items.pos_y;
		q_cmd.pz    = items.pos_z;
		q_cmd.op    = OP_LOAD;
		keep        = 1'b0;
		case (items.kind)
			KIND_LOAD: begin
				keep = 1'b1;
			end
			KIND_TRI: begin
				q_cmd.op    = OP_TRI;
				q_cmd.idx_a = items.corner_a[VIDX_W-1:0];
				q_cmd.idx_b = items.corner_b[VIDX_W-1:0];
				q_cmd.idx_c = items.corner_c[VIDX_W-1:0];
				keep        = tri_ok;
			end
			KIND_QUERY: begin
				q_cmd.op = (CNT_W'(items.vertex_index) < eff_count) ? OP_QUERY : OP_QOOR;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign q_push = items.valid && items.ready && keep;
endmodule

// ===== design/svn_queue.sv =====
module svn_queue import svn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head
);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W:0]   DEPTH_C = (PTR_W + 1)'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== design/svn_back.sv =====
module svn_back import svn_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  cmd_t         head,
	output logic         pop,
	output back_status_t status,
	svn_result_if.source results
);
	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_TRI_RD = 4'd2;
	localparam logic [3:0] S_TRI_MUL = 4'd3;
	localparam logic [3:0] S_ACC_RD = 4'd4;
	localparam logic [3:0] S_ACC_WR = 4'd5;
	localparam logic [3:0] S_Q_CHK  = 4'd6;
	localparam logic [3:0] S_Q_SHIFT = 4'd7;
	localparam logic [3:0] S_Q_SQ   = 4'd8;
	localparam logic [3:0] S_Q_SQRT = 4'd9;
	localparam logic [3:0] S_Q_DIV  = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	localparam int MUL_W  = 31;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MAG_W  = 30;
	localparam int SQ_W   = 63;
	localparam int LEN_W  = 31;
	localparam int QUO_W  = 17;
	localparam int NUM_W  = MAG_W + 17;
	localparam int REM_W  = LEN_W + 2;
	localparam int POSR_W = 3 * POS_W;
	localparam int ACCR_W = 3 * ACC_W;
	localparam logic signed [OUT_W-1:0] ONE_C = 16'sh7FFF;
	localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a, input logic signed [FACE_W-1:0] f);
		logic [ACC_W:0] sum;
		sum = {a[ACC_W-1], a} + {{(ACC_W+1-FACE_W){f[FACE_W-1]}}, f};
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			return sum[ACC_W] ? AMIN : AMAX;
		end
		return sum[ACC_W-1:0];
	endfunction

	logic [3:0]  state_q;
	logic [4:0]  step_q;
	logic [1:0]  corner_q;
	logic [VIDX_W-1:0] clr_q;
	cmd_t        cmd_q;

	logic signed [POS_W-1:0]  pa_q [3];
	logic signed [DIFF_W-1:0] u_q [3];
	logic signed [DIFF_W-1:0] w_q [3];
	logic signed [FACE_W-1:0] f_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  mag_q [3];
	logic              neg_q [3];
	logic [SQ_W-1:0]   sum_q;
	logic [SQ_W-1:0]   n_q;
	logic [SQ_W-1:0]   r_q;
	logic [SQ_W-1:0]   bit_q;
	logic [LEN_W-1:0]  len_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  num_lo_q;
	logic [QUO_W-1:0]  quo_q;
	logic signed [OUT_W-1:0] res_q [3];
	logic              res_fb_q;
	logic              res_oor_q;

	logic              out_valid_q;
	logic signed [OUT_W-1:0] out_x_q, out_y_q, out_z_q;
	logic              out_fb_q, out_oor_q;

	logic              pos_we, acc_we;
	logic [VIDX_W-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
	logic [POSR_W-1:0] pos_wdata, pos_rdata;
	logic [ACCR_W-1:0] acc_wdata, acc_rdata;
	logic [VIDX_W-1:0] corner_idx;
	logic signed [ACC_W-1:0] acc_rd [3];

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [POS_W-1:0]  pos_rd [3];

	logic [SQ_W-1:0]   r_plus;
	logic [SQ_W-1:0]   r_next, n_next;
	logic [NUM_W-1:0]  num_init;
	logic [REM_W-1:0]  rem_shift, den;
	logic              qbit;
	logic [QUO_W-1:0]  quo_next;
	logic signed [OUT_W-1:0] q_final;
	logic              done_load;
	logic              mag_fit;

	svn_ram #(.WIDTH(POSR_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rdata));

	svn_ram #(.WIDTH(ACCR_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.raddr(acc_raddr), .rdata(acc_rdata));

	assign pos_rd[0] = pos_rdata[POS_W-1:0];
	assign pos_rd[1] = pos_rdata[2*POS_W-1:POS_W];
	assign pos_rd[2] = pos_rdata[3*POS_W-1:2*POS_W];
	assign acc_rd[0] = acc_rdata[ACC_W-1:0];
	assign acc_rd[1] = acc_rdata[2*ACC_W-1:ACC_W];
	assign acc_rd[2] = acc_rdata[3*ACC_W-1:2*ACC_W];

	assign status.clearing = (state_q == S_CLEAR);
	assign pop = (state_q == S_IDLE) && head_valid;

	assign mag_fit = (mag_q[0][ACC_W-1:MAG_W] == '0) && (mag_q[1][ACC_W-1:MAG_W] == '0)
		&& (mag_q[2][ACC_W-1:MAG_W] == '0);

	always_comb begin
		case (corner_q)
			2'd0:    corner_idx = cmd_q.idx_a;
			2'd1:    corner_idx = cmd_q.idx_b;
			default: corner_idx = cmd_q.idx_c;
		endcase
	end

	// memory ports
	always_comb begin
		pos_we    = pop && (head.op == OP_LOAD);
		pos_waddr = head.idx_a;
		pos_wdata = {head.pz, head.py, head.px};
		case (step_q[1:0])
			2'd0:    pos_raddr = cmd_q.idx_a;
			2'd1:    pos_raddr = cmd_q.idx_b;
			default: pos_raddr = cmd_q.idx_c;
		endcase
		acc_we    = 1'b0;
		acc_waddr = corner_idx;
		acc_wdata = '0;
		acc_raddr = corner_idx;
		case (state_q)
			S_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
			end
			S_IDLE: begin
				acc_we    = pop && (head.op == OP_LOAD);
				acc_waddr = head.idx_a;
				acc_raddr = head.idx_a;
			end
			S_ACC_WR: begin
				acc_we    = 1'b1;
				acc_wdata = {sat_add(acc_rd[2], f_q[2]), sat_add(acc_rd[1], f_q[1]),
					sat_add(acc_rd[0], f_q[0])};
			end
			default: begin
				acc_we = 1'b0;
			end
		endcase
	end

	// shared multiplier: cross-product terms, then squares of magnitudes
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_TRI_MUL) begin
			case (step_q)
				5'd0: begin mul_a = MUL_W'(u_q[1]); mul_b = MUL_W'(w_q[2]); end
				5'd1: begin mul_a = MUL_W'(u_q[2]); mul_b = MUL_W'(w_q[1]); end
				5'd2: begin mul_a = MUL_W'(u_q[2]); mul_b = MUL_W'(w_q[0]); end
				5'd3: begin mul_a = MUL_W'(u_q[0]); mul_b = MUL_W'(w_q[2]); end
				5'd4: begin mul_a = MUL_W'(u_q[0]); mul_b = MUL_W'(w_q[1]); end
				5'd5: begin mul_a = MUL_W'(u_q[1]); mul_b = MUL_W'(w_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else begin
			case (step_q)
				5'd0: begin
					mul_a = {1'b0, mag_q[0][MAG_W-1:0]};
					mul_b = {1'b0, mag_q[0][MAG_W-1:0]};
				end
				5'd1: begin
					mul_a = {1'b0, mag_q[1][MAG_W-1:0]};
					mul_b = {1'b0, mag_q[1][MAG_W-1:0]};
				end
				5'd2: begin
					mul_a = {1'b0, mag_q[2][MAG_W-1:0]};
					mul_b = {1'b0, mag_q[2][MAG_W-1:0]};
				end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end
	assign mul_p = mul_a * mul_b;

	// one root bit a cycle
	assign r_plus = r_q + bit_q;
	always_comb begin
		if (n_q >= r_plus) begin
			n_next = n_q - r_plus;
			r_next = (r_q >> 1) + bit_q;
		end else begin
			n_next = n_q;
			r_next = r_q >> 1;
		end
	end

	// one quotient bit a cycle
	assign num_init  = {mag_q[corner_q][MAG_W-1:0], 16'b0} + NUM_W'(len_q);
	assign den       = {1'b0, len_q, 1'b0};
	assign rem_shift = {rem_q[REM_W-2:0], num_lo_q[QUO_W-1]};
	assign qbit      = (rem_shift >= den);
	assign quo_next  = {quo_q[QUO_W-2:0], qbit};
	always_comb begin
		if (neg_q[corner_q]) begin
			q_final = (quo_next > QUO_W'(32768)) ? 16'sh8000 : OUT_W'(-quo_next);
		end else begin
			q_final = (quo_next > QUO_W'(32767)) ? ONE_C : OUT_W'(quo_next);
		end
	end

	assign done_load = (state_q == S_DONE) && (!out_valid_q || results.ready);

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			S_IDLE: begin
				cmd_q     <= head;
				res_q[0]  <= '0;
				res_q[1]  <= ONE_C;
				res_q[2]  <= '0;
				res_fb_q  <= 1'b0;
				res_oor_q <= (head.op == OP_QOOR);
			end
			S_TRI_RD: begin
				if (step_q == 5'd1) begin
					pa_q <= pos_rd;
				end
				for (int i = 0; i < 3; i++) begin
					if (step_q == 5'd2) begin
						u_q[i] <= DIFF_W'(pos_rd[i]) - DIFF_W'(pa_q[i]);
					end
					if (step_q == 5'd3) begin
						w_q[i] <= DIFF_W'(pos_rd[i]) - DIFF_W'(pa_q[i]);
					end
				end
			end
			S_TRI_MUL: begin
				// even term opens a component, odd term subtracts from it
				case (step_q)
					5'd1: f_q[0] <= FACE_W'(prod_q);
					5'd2: f_q[0] <= f_q[0] - FACE_W'(prod_q);
					5'd3: f_q[1] <= FACE_W'(prod_q);
					5'd4: f_q[1] <= f_q[1] - FACE_W'(prod_q);
					5'd5: f_q[2] <= FACE_W'(prod_q);
					5'd6: f_q[2] <= f_q[2] - FACE_W'(prod_q);
					default: f_q[0] <= f_q[0];
				endcase
			end
			S_Q_CHK: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= acc_rd[i][ACC_W-1];
					mag_q[i] <= acc_rd[i][ACC_W-1] ? ACC_W'(0) - acc_rd[i] : acc_rd[i];
				end
				if (acc_rd[0] == '0 && acc_rd[1] == '0 && acc_rd[2] == '0) begin
					res_fb_q <= 1'b1;
				end
			end
			S_Q_SHIFT: begin
				if (!mag_fit) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
				sum_q <= '0;
			end
			S_Q_SQ: begin
				if (step_q != 5'd0) begin
					sum_q <= sum_q + SQ_W'(prod_q);
				end
				n_q   <= sum_q + SQ_W'(prod_q);
				r_q   <= '0;
				bit_q <= {1'b1, {(SQ_W-1){1'b0}}};
			end
			S_Q_SQRT: begin
				n_q   <= n_next;
				r_q   <= r_next;
				bit_q <= bit_q >> 2;
				len_q <= (r_next == '0) ? LEN_W'(1) : r_next[LEN_W-1:0];
			end
			S_Q_DIV: begin
				if (step_q == 5'd0) begin
					rem_q    <= REM_W'(num_init[NUM_W-1:QUO_W]);
					num_lo_q <= num_init[QUO_W-1:0];
					quo_q    <= '0;
				end else begin
					rem_q    <= qbit ? rem_shift - den : rem_shift;
					num_lo_q <= num_lo_q << 1;
					quo_q    <= quo_next;
					if (step_q == 5'(QUO_W)) begin
						res_q[corner_q] <= q_final;
					end
				end
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
		if (done_load) begin
			out_x_q   <= res_q[0];
			out_y_q   <= res_q[1];
			out_z_q   <= res_q[2];
			out_fb_q  <= res_fb_q;
			out_oor_q <= res_oor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= '0;
			corner_q    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					step_q   <= '0;
					corner_q <= '0;
					if (pop) begin
						case (head.op)
							OP_TRI:   state_q <= S_TRI_RD;
							OP_QUERY: state_q <= S_Q_CHK;
							OP_QOOR:  state_q <= S_DONE;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_TRI_RD: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd3) begin
						step_q  <= '0;
						state_q <= S_TRI_MUL;
					end
				end
				S_TRI_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd6) begin
						step_q  <= '0;
						state_q <= S_ACC_RD;
					end
				end
				S_ACC_RD: begin
					state_q <= S_ACC_WR;
				end
				S_ACC_WR: begin
					corner_q <= corner_q + 1'b1;
					state_q  <= (corner_q == 2'd2) ? S_IDLE : S_ACC_RD;
				end
				S_Q_CHK: begin
					if (acc_rd[0] == '0 && acc_rd[1] == '0 && acc_rd[2] == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_Q_SHIFT;
					end
				end
				S_Q_SHIFT: begin
					// halve until every magnitude fits the square unit
					if (mag_fit) begin
						state_q <= S_Q_SQ;
						step_q  <= '0;
					end
				end
				S_Q_SQ: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd3) begin
						step_q  <= '0;
						state_q <= S_Q_SQRT;
					end
				end
				S_Q_SQRT: begin
					if (bit_q[0]) begin
						state_q  <= S_Q_DIV;
						step_q   <= '0;
						corner_q <= '0;
					end
				end
				S_Q_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'(QUO_W)) begin
						step_q   <= '0;
						corner_q <= corner_q + 1'b1;
						if (corner_q == 2'd2) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (done_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid              = out_valid_q;
	assign results.normal_x           = out_x_q;
	assign results.normal_y           = out_y_q;
	assign results.normal_z           = out_z_q;
	assign results.used_fallback      = out_fb_q;
	assign results.index_out_of_range = out_oor_q;

	a_acc_rmw_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC_WR |-> acc_waddr == $past(acc_raddr))
		else $error("accumulator write address differs from its read");

	a_shift_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_Q_SQ |-> (mag_q[0][ACC_W-1:MAG_W] == '0 && mag_q[1][ACC_W-1:MAG_W] == '0
			&& mag_q[2][ACC_W-1:MAG_W] == '0))
		else $error("magnitude too wide for square unit");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_Q_DIV |-> len_q != '0)
		else $error("zero divisor in normalize");

	a_sqrt_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_SQRT && bit_q[0]) |=> state_q == S_Q_DIV)
		else $error("root did not hand over to divider");
endmodule

// ===== design/smooth_vertex_normals_core.sv =====
// Channel  Dir  Beat contents
// items    in   kind, vertex_index, pos_x/y/z (Q15.8), corner_a/b/c
// results  out  normal_x/y/z (Q1.15), used_fallback, index_out_of_range
// cfg      in   cfg_wr_en, cfg_wr_data: vertex_count, no read-back
//
// After reset the accumulator memory is swept to zero, one entry a cycle;
// items is held not ready meanwhile.
// Load: position written and accumulator entry cleared as it is popped.
// Triangle: 3 position reads, 6 shared multiplies, 3 accumulator RMWs.
// Query: s (0 to 34) halving steps, then the one-bit-a-cycle square root
// and divider, the divider run for each component.
// A two-entry queue parts front and back; items keeps flowing while a
// result beat waits in the output register, until the queue is full.
module smooth_vertex_normals_core import svn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	svn_item_if.sink         items,
	svn_result_if.source     results,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data
);
	back_status_t status;
	logic         q_full;
	logic         q_push;
	cmd_t         q_cmd;
	logic         q_pop;
	logic         q_head_valid;
	cmd_t         q_head;

	// classify beats, check indices against vertex_count, drop skipped work
	svn_front u_front (
		.clk(clk), .arst_n(arst_n), .items(items),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.status(status), .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd));

	// hold classified commands between the two halves
	svn_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_cmd(q_cmd),
		.pop(q_pop), .full(q_full), .head_valid(q_head_valid), .head(q_head));

	// advance one command at a time through memories and arithmetic
	svn_back u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(q_head_valid), .head(q_head),
		.pop(q_pop), .status(status), .results(results));
endmodule
